// ===== sv/mset_pkg.sv =====
// Shared types and constants for the multi-slot event timer.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps

package mset_pkg;

   // Number of timer slots (1 to 255).
   localparam int SLOTS = 8;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_REGISTER   = 2'd1;
   localparam logic [1:0] OP_UNREGISTER = 2'd2;
   localparam logic [1:0] OP_TAKE       = 2'd3;

   localparam logic [1:0] MODE_ONE_SHOT = 2'd0;
   localparam logic [1:0] MODE_PERIODIC = 2'd1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  slot;
      logic [31:0] period;
      logic [1:0]  repeat_mode;
   } mset_req_type;

   typedef struct packed {
      logic status;
      logic taken_flag;
   } mset_rsp_type;

   // One word of the slot memory.
   typedef struct packed {
      logic [31:0] period;
      logic [31:0] count;
   } mset_entry_type;

   typedef struct packed {
      logic load;      // capture the request at its transfer
      logic exec;      // execute the operation and load the result
      logic sweep_rd;  // read the slot at the sweep index
   } mset_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic sweep_last;
   } mset_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SWEEP,
      ST_SWEEP_END,
      ST_RESPOND
   } mset_state_type;

endpackage

// ===== sv/mset_ctrl.sv =====
// Controller state machine of the multi-slot event timer.
// Depends on mset_pkg; drives the datapath through command and status structs.
`timescale 1ns / 1ps

module mset_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output mset_pkg::mset_cmd_type cmd,
   input  mset_pkg::mset_stat_type stat
);

   mset_pkg::mset_state_type state_ff;
   mset_pkg::mset_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mset_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         mset_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = mset_pkg::ST_DISPATCH;
            end
         end
         mset_pkg::ST_DISPATCH: begin
            // A tick also loads its (always accepted) result here.
            cmd.exec = 1'b1;
            state_in = stat.is_tick ? mset_pkg::ST_SWEEP : mset_pkg::ST_RESPOND;
         end
         mset_pkg::ST_SWEEP: begin
            cmd.sweep_rd = 1'b1;
            if (stat.sweep_last) begin
               state_in = mset_pkg::ST_SWEEP_END;
            end
         end
         mset_pkg::ST_SWEEP_END: begin
            // The last slot is written back during this cycle.
            state_in = mset_pkg::ST_RESPOND;
         end
         mset_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = mset_pkg::ST_IDLE;
         end
         default: begin
            state_in = mset_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/mset_datapath.sv =====
// Datapath of the multi-slot event timer: request and result registers,
// slot memory with per-slot valid, pending and mode flags, and the tick sweep.
// Depends on mset_pkg.
`timescale 1ns / 1ps

module mset_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  mset_pkg::mset_req_type  req_data,
   output mset_pkg::mset_rsp_type  rsp_data,
   input  mset_pkg::mset_cmd_type  cmd,
   output mset_pkg::mset_stat_type stat
);

   mset_pkg::mset_entry_type slot_mem [mset_pkg::SLOTS];

   mset_pkg::mset_req_type   req_ff;
   mset_pkg::mset_req_type   req_in;
   mset_pkg::mset_rsp_type   rsp_ff;
   mset_pkg::mset_rsp_type   rsp_in;

   // A slot whose valid bit is clear is inactive and is skipped by the sweep write-back.
   logic [mset_pkg::SLOTS-1:0] val_ff;
   logic [mset_pkg::SLOTS-1:0] val_in;
   logic [mset_pkg::SLOTS-1:0] pend_ff;
   logic [mset_pkg::SLOTS-1:0] pend_in;
   logic [mset_pkg::SLOTS-1:0] prd_ff;
   logic [mset_pkg::SLOTS-1:0] prd_in;

   logic [mset_pkg::IDX_W-1:0] sweep_idx_ff;
   logic [mset_pkg::IDX_W-1:0] sweep_idx_in;

   // Write-back stage of the sweep.
   mset_pkg::mset_entry_type   rd_data_ff;
   logic                       rd_val_ff;
   logic [mset_pkg::IDX_W-1:0] wb_idx_ff;
   logic                       wb_go_ff;

   logic                       mem_we;
   logic [mset_pkg::IDX_W-1:0] mem_wa;
   mset_pkg::mset_entry_type   mem_wd;

   logic                       in_range;
   logic                       bad_reg;
   logic [mset_pkg::IDX_W-1:0] sidx;
   logic [31:0]                cnt_dec;

   assign in_range = req_ff.slot < 8'(mset_pkg::SLOTS);
   assign sidx     = req_ff.slot[mset_pkg::IDX_W-1:0];
   assign bad_reg  = !in_range || (req_ff.period == 32'd0) ||
                     (req_ff.repeat_mode > mset_pkg::MODE_PERIODIC);
   assign cnt_dec  = rd_data_ff.count - 32'd1;

   assign stat.is_tick    = (req_ff.operation == mset_pkg::OP_TICK);
   assign stat.sweep_last = (sweep_idx_ff == mset_pkg::IDX_W'(mset_pkg::SLOTS - 1));
   assign rsp_data        = rsp_ff;

   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      val_in       = val_ff;
      pend_in      = pend_ff;
      prd_in       = prd_ff;
      sweep_idx_in = sweep_idx_ff;
      mem_we       = 1'b0;
      mem_wa       = sidx;
      mem_wd       = '{period: req_ff.period, count: req_ff.period};

      if (cmd.load) begin
         req_in = req_data;
      end

      if (cmd.exec) begin
         rsp_in       = '0;
         sweep_idx_in = '0;
         unique case (req_ff.operation)
            mset_pkg::OP_TICK: begin
               rsp_in.status = mset_pkg::STATUS_OK;
            end
            mset_pkg::OP_REGISTER: begin
               if (bad_reg) begin
                  rsp_in.status = mset_pkg::STATUS_REJECT;
               end else begin
                  mem_we        = 1'b1;
                  val_in[sidx]  = 1'b1;
                  pend_in[sidx] = 1'b0;
                  prd_in[sidx]  = req_ff.repeat_mode[0];
               end
            end
            mset_pkg::OP_UNREGISTER: begin
               if (!in_range) begin
                  rsp_in.status = mset_pkg::STATUS_REJECT;
               end else begin
                  val_in[sidx]  = 1'b0;
                  pend_in[sidx] = 1'b0;
                  prd_in[sidx]  = 1'b0;
               end
            end
            mset_pkg::OP_TAKE: begin
               if (!in_range) begin
                  rsp_in.status = mset_pkg::STATUS_REJECT;
               end else begin
                  rsp_in.taken_flag = pend_ff[sidx];
                  pend_in[sidx]     = 1'b0;
               end
            end
            default: begin
               rsp_in.status = mset_pkg::STATUS_REJECT;
            end
         endcase
      end

      if (cmd.sweep_rd) begin
         sweep_idx_in = sweep_idx_ff + 1'b1;
      end

      // Sweep write-back; an active slot never holds a zero count.
      if (wb_go_ff && rd_val_ff) begin
         mem_wa = wb_idx_ff;
         if (cnt_dec == 32'd0) begin
            pend_in[wb_idx_ff] = 1'b1;
            if (prd_ff[wb_idx_ff]) begin
               mem_we = 1'b1;
               mem_wd = '{period: rd_data_ff.period, count: rd_data_ff.period};
            end else begin
               val_in[wb_idx_ff] = 1'b0;
            end
         end else begin
            mem_we = 1'b1;
            mem_wd = '{period: rd_data_ff.period, count: cnt_dec};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      if (cmd.sweep_rd) begin
         rd_data_ff <= slot_mem[sweep_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff       <= '0;
         pend_ff      <= '0;
         prd_ff       <= '0;
         sweep_idx_ff <= '0;
         wb_go_ff     <= 1'b0;
         rd_val_ff    <= 1'b0;
         wb_idx_ff    <= '0;
      end else begin
         val_ff       <= val_in;
         pend_ff      <= pend_in;
         prd_ff       <= prd_in;
         sweep_idx_ff <= sweep_idx_in;
         wb_go_ff     <= cmd.sweep_rd;
         rd_val_ff    <= val_ff[sweep_idx_ff];
         wb_idx_ff    <= sweep_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== sv/multi_slot_event_timer_unit.sv =====
// Multi-slot event timer. A tick sweeps all SLOTS slots through the slot
// memory, one read and one write-back per cycle, going from dispatch through
// the sweep and sweep end states to the result strobe. Register, unregister
// and take flag go from dispatch straight to the result strobe. Synchronous
// reset leaves every slot inactive at once through per-slot valid bits; the
// result side is never stalled.
`timescale 1ns / 1ps

module multi_slot_event_timer_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mset_pkg::mset_req_type req_data,
   output logic                   rsp_valid,
   output mset_pkg::mset_rsp_type rsp_data
);

   mset_pkg::mset_cmd_type  cmd;
   mset_pkg::mset_stat_type stat;

   mset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   mset_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

// ===== sv/mset_checker.sv =====
// Port-level checks for the multi-slot event timer, bound to the top level.
// Depends on mset_pkg for the port types.
`timescale 1ns / 1ps

module mset_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input mset_pkg::mset_rsp_type rsp_data
);

   // A transfer always makes the unit busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after a request transfer");

   // A result is only ever presented while an item is in flight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // Delivering the result frees the unit and the strobe lasts one cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("unit still busy or strobing after its result");

   // The unit never turns busy without a transfer.
   assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !busy)
      else $error("unit became busy without a request transfer");

   // A set taken flag is never reported together with a rejection.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.taken_flag) |-> (rsp_data.status == mset_pkg::STATUS_OK))
      else $error("taken flag reported with a rejection");

endmodule

bind multi_slot_event_timer_unit mset_checker u_mset_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
